>>> sv/ssp_pkg.sv
`default_nettype none

package ssp_pkg;

    // Sizes of the particle store and of the fixed-point fields
    localparam int PARTICLES  = 64;
    localparam int IDX_W      = $clog2(PARTICLES);
    localparam int CNT_W      = $clog2(PARTICLES + 1);
    localparam int POS_W      = 16;
    localparam int RAD_W      = 15;
    localparam int VEL_W      = 32;
    localparam int CFG_W      = 16;
    localparam int K_W        = 24;
    localparam int KOV_W      = K_W + POS_W;
    localparam int U_W        = POS_W + 1;
    localparam int IMP_W      = 25;
    localparam int D2_W       = 2 * POS_W;
    localparam int POS_WORD_W = 3 * POS_W + RAD_W;
    localparam int VEL_WORD_W = 3 * VEL_W;
    localparam int DATA_W     = 72;
    localparam int AXES       = 3;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_COUNT    = 2'd0;
    localparam logic [1:0] CFG_STRENGTH = 2'd1;
    localparam logic [1:0] CFG_DT       = 2'd2;
    localparam logic [1:0] CFG_DAMP     = 2'd3;

    // Input word kinds
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic [IDX_W-1:0] wr_addr;
        logic [1:0]       axis;
        logic             load;
        logic             latch_i;
        logic             latch_j;
        logic             sq_acc;
        logic             sqrt_start;
        logic             kov_en;
        logic             div_start;
        logic             imp_en;
        logic             kick;
        logic             wr_j;
        logic             wr_i_vel;
        logic             int_latch;
        logic             damp;
        logic             adv;
        logic             emit;
        logic             last;
    } ssp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             skip;
        logic             sqrt_done;
        logic             div_done;
        logic             out_free;
    } ssp_stat_t;

    // Clamp a widened velocity sum to the signed velocity range
    function automatic logic [VEL_W-1:0] sat_vel(input logic [VEL_W+1:0] v);
        logic [VEL_W-1:0] r;
        if (v[VEL_W+1:VEL_W-1] == 3'b000 || v[VEL_W+1:VEL_W-1] == 3'b111)
        begin
            r = v[VEL_W-1:0];
        end
        else if (v[VEL_W+1])
        begin
            r = {1'b1, {(VEL_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(VEL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/ssp_ram.sv
`default_nettype none

module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/ssp_sqrt.sv
`default_nettype none

module ssp_sqrt import ssp_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [D2_W-1:0]  operand,
    output      logic [POS_W-1:0] root,
    output      logic             busy
);

    localparam int STEP_W = $clog2(POS_W);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [D2_W-1:0]   a_reg, a_next;
    logic [POS_W+1:0]  r_reg, r_next;
    logic [POS_W-1:0]  q_reg, q_next;
    logic [POS_W+3:0]  r_sh;
    logic [POS_W+3:0]  trial;
    logic [POS_W+3:0]  diff;

    // One result bit per cycle, two operand bits taken in each time
    always_comb
    begin
        r_sh      = {r_reg, a_reg[D2_W-1 -: 2]};
        trial     = {2'b00, q_reg, 2'b01};
        diff      = r_sh - trial;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = operand;
            r_next    = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            a_next   = {a_reg[D2_W-3:0], 2'b00};
            cnt_next = cnt_reg + STEP_W'(1);
            if (r_sh >= trial)
            begin
                r_next = diff[POS_W+1:0];
                q_next = {q_reg[POS_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh[POS_W+1:0];
                q_next = {q_reg[POS_W-2:0], 1'b0};
            end
            if (cnt_reg == STEP_W'(POS_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign root = q_reg;
    assign busy = busy_reg;

endmodule

`default_nettype wire

>>> sv/ssp_div.sv
`default_nettype none

module ssp_div import ssp_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [POS_W-1:0] numer,
    input  wire logic [POS_W-1:0] denom,
    output      logic [U_W-1:0]   quot,
    output      logic             busy
);

    localparam int NUM_W  = 2 * POS_W;
    localparam int STEP_W = $clog2(NUM_W);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]  n_reg, n_next;
    logic [POS_W-1:0]  d_reg, d_next;
    logic [POS_W-1:0]  rem_reg, rem_next;
    logic [U_W-1:0]    q_reg, q_next;
    logic [POS_W:0]    r_sh;
    logic [POS_W:0]    diff;

    // Restoring division of numer * 2^16 by denom, one quotient bit per cycle
    always_comb
    begin
        r_sh      = {rem_reg, n_reg[NUM_W-1]};
        diff      = r_sh - {1'b0, d_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_next    = {numer, {POS_W{1'b0}}};
            d_next    = denom;
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            n_next   = {n_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg + STEP_W'(1);
            if (r_sh >= {1'b0, d_reg})
            begin
                rem_next = diff[POS_W-1:0];
                q_next   = {q_reg[U_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = r_sh[POS_W-1:0];
                q_next   = {q_reg[U_W-2:0], 1'b0};
            end
            if (cnt_reg == STEP_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;
    assign busy = busy_reg;

endmodule

`default_nettype wire

>>> sv/ssp_ctrl.sv
`default_nettype none

module ssp_ctrl import ssp_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_opcode,
    output      logic      in_ready,
    input  wire ssp_stat_t stat,
    output      ssp_cmd_t  cmd
);

    typedef enum logic [19:0] {
        ST_IDLE      = 20'h00001,
        ST_RD_I      = 20'h00002,
        ST_LATCH_I   = 20'h00004,
        ST_RD_J      = 20'h00008,
        ST_LATCH_J   = 20'h00010,
        ST_SQ        = 20'h00020,
        ST_CMP       = 20'h00040,
        ST_SQRT      = 20'h00080,
        ST_OV        = 20'h00100,
        ST_DIV_GO    = 20'h00200,
        ST_DIV_WAIT  = 20'h00400,
        ST_IMP       = 20'h00800,
        ST_KICK      = 20'h01000,
        ST_WR_J      = 20'h02000,
        ST_WR_I      = 20'h04000,
        ST_INT_RD    = 20'h08000,
        ST_INT_LATCH = 20'h10000,
        ST_DAMP      = 20'h20000,
        ST_ADV       = 20'h40000,
        ST_INT_WR    = 20'h80000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [1:0]       axis_reg, axis_next;
    logic [CNT_W-1:0] j_inc;
    logic [CNT_W-1:0] i_inc;
    logic [CNT_W-1:0] i_inc2;

    always_comb
    begin
        j_inc      = j_reg + CNT_W'(1);
        i_inc      = i_reg + CNT_W'(1);
        i_inc2     = i_reg + CNT_W'(2);
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        axis_next  = axis_reg;
        in_ready   = 1'b0;
        cmd         = '0;
        cmd.axis    = axis_reg;
        cmd.rd_addr = i_reg[IDX_W-1:0];
        cmd.wr_addr = i_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (stat.count != '0)
                    begin
                        n_next = stat.count;
                        i_next = '0;
                        if (stat.count == CNT_W'(1))
                        begin
                            state_next = ST_INT_RD;
                        end
                        else
                        begin
                            state_next = ST_RD_I;
                        end
                    end
                end
            end
            ST_RD_I:
            begin
                state_next = ST_LATCH_I;
            end
            ST_LATCH_I:
            begin
                cmd.latch_i = 1'b1;
                j_next      = i_inc;
                state_next  = ST_RD_J;
            end
            ST_RD_J:
            begin
                cmd.rd_addr = j_reg[IDX_W-1:0];
                state_next  = ST_LATCH_J;
            end
            ST_LATCH_J:
            begin
                cmd.latch_j = 1'b1;
                axis_next   = AXIS_X;
                state_next  = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq_acc = 1'b1;
                if (axis_reg == AXIS_Z)
                begin
                    axis_next  = AXIS_X;
                    state_next = ST_CMP;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_CMP:
            begin
                if (stat.skip)
                begin
                    // Pair does not interact: move to the next partner
                    if (j_inc < n_reg)
                    begin
                        j_next     = j_inc;
                        state_next = ST_RD_J;
                    end
                    else
                    begin
                        state_next = ST_WR_I;
                    end
                end
                else
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = ST_OV;
                end
            end
            ST_OV:
            begin
                cmd.kov_en = 1'b1;
                axis_next  = AXIS_X;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_IMP;
                end
            end
            ST_IMP:
            begin
                cmd.imp_en = 1'b1;
                state_next = ST_KICK;
            end
            ST_KICK:
            begin
                cmd.kick = 1'b1;
                if (axis_reg == AXIS_Z)
                begin
                    state_next = ST_WR_J;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_DIV_GO;
                end
            end
            ST_WR_J:
            begin
                cmd.wr_j    = 1'b1;
                cmd.wr_addr = j_reg[IDX_W-1:0];
                if (j_inc < n_reg)
                begin
                    j_next     = j_inc;
                    state_next = ST_RD_J;
                end
                else
                begin
                    state_next = ST_WR_I;
                end
            end
            ST_WR_I:
            begin
                cmd.wr_i_vel = 1'b1;
                if (i_inc2 < n_reg)
                begin
                    i_next     = i_inc;
                    state_next = ST_RD_I;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_INT_RD;
                end
            end
            ST_INT_RD:
            begin
                state_next = ST_INT_LATCH;
            end
            ST_INT_LATCH:
            begin
                cmd.int_latch = 1'b1;
                axis_next     = AXIS_X;
                state_next    = ST_DAMP;
            end
            ST_DAMP:
            begin
                cmd.damp   = 1'b1;
                state_next = ST_ADV;
            end
            ST_ADV:
            begin
                cmd.adv = 1'b1;
                if (axis_reg == AXIS_Z)
                begin
                    state_next = ST_INT_WR;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_DAMP;
                end
            end
            ST_INT_WR:
            begin
                // Write back and report once the output register is free
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = (i_inc == n_reg);
                    if (i_inc == n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = ST_INT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
            axis_reg  <= AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/ssp_dp.sv
`default_nettype none

module ssp_dp import ssp_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ssp_cmd_t         cmd,
    output      ssp_stat_t        stat,
    input  wire logic [IDX_W-1:0] slot,
    input  wire logic [POS_W-1:0] load_x,
    input  wire logic [POS_W-1:0] load_y,
    input  wire logic [POS_W-1:0] load_z,
    input  wire logic [RAD_W-1:0] load_radius,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_addr,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             out_ready,
    output      logic             out_valid,
    output      logic [IDX_W-1:0] out_index,
    output      logic [POS_W-1:0] out_x,
    output      logic [POS_W-1:0] out_y,
    output      logic [POS_W-1:0] out_z,
    output      logic [RAD_W-1:0] out_radius,
    output      logic             out_last
);

    // Configuration registers
    logic [CNT_W-1:0] count_reg;
    logic [CFG_W-1:0] strength_reg;
    logic [CFG_W-1:0] dt_reg;
    logic [CFG_W-1:0] damp_reg;

    // Working registers of the pair and integration passes
    logic [POS_W-1:0] pi_reg [AXES];
    logic [RAD_W-1:0] ri_reg;
    logic [VEL_W-1:0] vi_reg [AXES];
    logic [VEL_W-1:0] vj_reg [AXES];
    logic [POS_W-1:0] m_reg  [AXES];
    logic [POS_W-1:0] rsum_reg;
    logic [D2_W-1:0]  d2_reg;
    logic [K_W-1:0]   k_reg;
    logic [KOV_W-1:0] kov_reg;
    logic [IMP_W-1:0] imp_reg;

    // Output register
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic [POS_W-1:0] out_x_reg;
    logic [POS_W-1:0] out_y_reg;
    logic [POS_W-1:0] out_z_reg;
    logic [RAD_W-1:0] out_radius_reg;
    logic             out_last_reg;

    // Memory ports
    logic                  pos_we;
    logic [IDX_W-1:0]      pos_waddr;
    logic [POS_WORD_W-1:0] pos_wdata;
    logic [POS_WORD_W-1:0] pos_rdata;
    logic                  vel_we;
    logic [IDX_W-1:0]      vel_waddr;
    logic [VEL_WORD_W-1:0] vel_wdata;
    logic [VEL_WORD_W-1:0] vel_rdata;

    // Arithmetic
    logic [POS_W-1:0]     m_a;
    logic [POS_W-1:0]     m_mag;
    logic [D2_W-1:0]      m_sq;
    logic [D2_W-1:0]      rsum_sq;
    logic [POS_W-1:0]     pair_dist;
    logic                 sqrt_busy;
    logic [U_W-1:0]       u_val;
    logic                 div_busy;
    logic [2*CFG_W-1:0]   k_prod;
    logic [KOV_W+U_W-1:0] imp_prod;
    logic [IMP_W:0]       simp;
    logic [VEL_W+1:0]     vi_sum;
    logic [VEL_W+1:0]     vj_sum;
    logic [VEL_W-1:0]     v_a;
    logic [VEL_W-1:0]     v_mag;
    logic [CFG_W-1:0]     mul_b;
    logic [VEL_W+CFG_W-1:0] v_prod;
    logic [VEL_W-1:0]     damp_mg;
    logic [POS_W-1:0]     delta;
    logic [CNT_W-1:0]     count_eff;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= CNT_W'(64);
            strength_reg <= CFG_W'(256);
            dt_reg       <= CFG_W'(1092);
            damp_reg     <= CFG_W'(64225);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_COUNT:    count_reg    <= cfg_data[CNT_W-1:0];
                CFG_STRENGTH: strength_reg <= cfg_data;
                CFG_DT:       dt_reg       <= cfg_data;
                CFG_DAMP:     damp_reg     <= cfg_data;
                default:      count_reg    <= count_reg;
            endcase
        end
    end

    assign count_eff = (count_reg > CNT_W'(PARTICLES)) ? CNT_W'(PARTICLES) : count_reg;

    // Position and radius memory: x, y, z, radius from the low bits up
    assign pos_we    = cmd.load | cmd.emit;
    assign pos_waddr = cmd.load ? slot : cmd.wr_addr;
    assign pos_wdata = cmd.load ? {load_radius, load_z, load_y, load_x}
                                : {ri_reg, pi_reg[2], pi_reg[1], pi_reg[0]};

    ssp_ram #(.WIDTH(POS_WORD_W), .DEPTH(PARTICLES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (cmd.rd_addr),
        .rdata (pos_rdata)
    );

    // Velocity memory: x, y, z from the low bits up
    assign vel_we    = cmd.load | cmd.wr_j | cmd.wr_i_vel | cmd.emit;
    assign vel_waddr = cmd.load ? slot : cmd.wr_addr;
    always_comb
    begin
        if (cmd.load)
        begin
            vel_wdata = '0;
        end
        else if (cmd.wr_j)
        begin
            vel_wdata = {vj_reg[2], vj_reg[1], vj_reg[0]};
        end
        else
        begin
            vel_wdata = {vi_reg[2], vi_reg[1], vi_reg[0]};
        end
    end

    ssp_ram #(.WIDTH(VEL_WORD_W), .DEPTH(PARTICLES)) u_vel_ram (
        .clk   (clk),
        .we    (vel_we),
        .waddr (vel_waddr),
        .wdata (vel_wdata),
        .raddr (cmd.rd_addr),
        .rdata (vel_rdata)
    );

    // Magnitude of the selected displacement and its square
    assign m_a     = m_reg[cmd.axis];
    assign m_mag   = m_a[POS_W-1] ? (~m_a + POS_W'(1)) : m_a;
    assign m_sq    = m_mag * m_mag;
    assign rsum_sq = rsum_reg * rsum_reg;
    assign k_prod  = strength_reg * dt_reg;

    ssp_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sqrt_start),
        .operand (d2_reg),
        .root    (pair_dist),
        .busy    (sqrt_busy)
    );

    ssp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (m_mag),
        .denom (pair_dist),
        .quot  (u_val),
        .busy  (div_busy)
    );

    // Impulse with the sign of the displacement, then saturated sums
    assign imp_prod = kov_reg * u_val;
    assign simp     = m_a[POS_W-1] ? (~{1'b0, imp_reg} + (IMP_W+1)'(1)) : {1'b0, imp_reg};
    assign vi_sum   = {{2{vi_reg[cmd.axis][VEL_W-1]}}, vi_reg[cmd.axis]}
                    - {{(VEL_W+1-IMP_W){simp[IMP_W]}}, simp};
    assign vj_sum   = {{2{vj_reg[cmd.axis][VEL_W-1]}}, vj_reg[cmd.axis]}
                    + {{(VEL_W+1-IMP_W){simp[IMP_W]}}, simp};

    // Shared multiplier of damping and integration
    assign v_a     = vi_reg[cmd.axis];
    assign v_mag   = v_a[VEL_W-1] ? (~v_a + VEL_W'(1)) : v_a;
    assign mul_b   = cmd.damp ? damp_reg : dt_reg;
    assign v_prod  = v_mag * mul_b;
    assign damp_mg = v_prod[VEL_W+CFG_W-1:CFG_W];
    assign delta   = v_prod[CFG_W+POS_W-1:CFG_W];

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_i || cmd.int_latch)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                pi_reg[a] <= pos_rdata[a*POS_W +: POS_W];
                vi_reg[a] <= vel_rdata[a*VEL_W +: VEL_W];
            end
            ri_reg <= pos_rdata[POS_WORD_W-1 -: RAD_W];
            k_reg  <= k_prod[K_W+7:8];
        end
        if (cmd.latch_j)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                m_reg[a]  <= pos_rdata[a*POS_W +: POS_W] - pi_reg[a];
                vj_reg[a] <= vel_rdata[a*VEL_W +: VEL_W];
            end
            rsum_reg <= {1'b0, ri_reg} + {1'b0, pos_rdata[POS_WORD_W-1 -: RAD_W]};
        end
        if (cmd.sq_acc)
        begin
            d2_reg <= ((cmd.axis == AXIS_X) ? '0 : d2_reg) + m_sq;
        end
        if (cmd.kov_en)
        begin
            kov_reg <= k_reg * (rsum_reg - pair_dist);
        end
        if (cmd.imp_en)
        begin
            imp_reg <= imp_prod[KOV_W+U_W-1-(KOV_W+U_W-32-IMP_W) -: IMP_W];
        end
        if (cmd.kick)
        begin
            vi_reg[cmd.axis] <= sat_vel(vi_sum);
            vj_reg[cmd.axis] <= sat_vel(vj_sum);
        end
        if (cmd.damp)
        begin
            vi_reg[cmd.axis] <= v_a[VEL_W-1] ? (~damp_mg + VEL_W'(1)) : damp_mg;
        end
        if (cmd.adv)
        begin
            pi_reg[cmd.axis] <= v_a[VEL_W-1] ? (pi_reg[cmd.axis] - delta)
                                             : (pi_reg[cmd.axis] + delta);
        end
        if (cmd.emit)
        begin
            out_index_reg  <= cmd.wr_addr;
            out_x_reg      <= pi_reg[0];
            out_y_reg      <= pi_reg[1];
            out_z_reg      <= pi_reg[2];
            out_radius_reg <= ri_reg;
            out_last_reg   <= cmd.last;
        end
    end

    // Output word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat.count     = count_eff;
        stat.skip      = (d2_reg == '0) || (d2_reg >= rsum_sq);
        stat.sqrt_done = ~sqrt_busy;
        stat.div_done  = ~div_busy;
        stat.out_free  = ~out_valid_reg | out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_z      = out_z_reg;
    assign out_radius = out_radius_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

>>> sv/soft_sphere_periodic_step.sv
`default_nettype none

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser opcode; tdata slot, x, y, z, radius
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata index, x, y, z, radius; tlast last
// cfg       in         cfg_we (no wait)              cfg_addr register, cfg_data value
//
// A step takes a square root and three divides, one per axis, for each overlapping
// pair; pairs that do not overlap, or that coincide, skip both. Each particle then
// goes through damping, integration and write-back through the memories.
// Reset returns the controller and configuration to their defaults; particle memories are not cleared.
// A stalled output holds the next report in the integration pass.

module soft_sphere_periodic_step import ssp_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output      logic              s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,  // slot, load_x, load_y, load_z, load_radius
    input  wire logic              s_axis_tuser,  // opcode
    output      logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output      logic [DATA_W-1:0] m_axis_tdata,  // out_index, out_x, out_y, out_z, out_radius
    output      logic              m_axis_tlast,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int FIELD_W = IDX_W + 3 * POS_W + RAD_W;

    ssp_cmd_t         cmd;
    ssp_stat_t        stat;
    logic [IDX_W-1:0] out_index;
    logic [POS_W-1:0] out_x;
    logic [POS_W-1:0] out_y;
    logic [POS_W-1:0] out_z;
    logic [RAD_W-1:0] out_radius;

    ssp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ssp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .slot        (s_axis_tdata[IDX_W-1:0]),
        .load_x      (s_axis_tdata[IDX_W +: POS_W]),
        .load_y      (s_axis_tdata[IDX_W+POS_W +: POS_W]),
        .load_z      (s_axis_tdata[IDX_W+2*POS_W +: POS_W]),
        .load_radius (s_axis_tdata[IDX_W+3*POS_W +: RAD_W]),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_index   (out_index),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .out_radius  (out_radius),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {{(DATA_W-FIELD_W){1'b0}}, out_radius, out_z, out_y, out_x, out_index};

    // A load word never produces a report
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD && !m_axis_tvalid)
        |=> !m_axis_tvalid)
    else $error("load word produced a report");

    // The final report of a step carries the highest active index
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast)
        |-> (out_index == IDX_W'(stat.count - CNT_W'(1))))
    else $error("last flag on wrong particle");

    // The square root and the divider are never busy together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(!stat.sqrt_done && !stat.div_done))
    else $error("root and divide units overlap");

endmodule

`default_nettype wire
